// ===== design/spl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority list package
// Sizes, codes, command and status types shared by the list engine.
// ----------------------------------------------------------------------------
package spl_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int MAX_WAYS   = 16;
  localparam int TABLE_SIZE = SLOT_COUNT + 2;
  localparam int ID_W       = $clog2(TABLE_SIZE);
  localparam int BKT_W      = $clog2(TABLE_SIZE + MAX_WAYS + 1);
  localparam int I_W        = $clog2(MAX_WAYS + 1);
  localparam int SLOT_W     = 10;
  localparam int NPRIO_W    = 32;
  localparam int PRIO_W     = 34;
  localparam int WORD_W     = 64;
  localparam int WAY_W      = 5;
  localparam int RES_W      = 11;

  localparam logic [ID_W-1:0] HEAD_ID = ID_W'(SLOT_COUNT);
  localparam logic [ID_W-1:0] TAIL_ID = ID_W'(SLOT_COUNT + 1);
  localparam logic signed [PRIO_W-1:0] HEAD_PRIO = PRIO_W'(64'h1_0000_0000);
  localparam logic signed [PRIO_W-1:0] TAIL_PRIO = '1;

  typedef enum logic [1:0] {
    FUNC_UPDATE     = 2'd0,
    FUNC_DELETE     = 2'd1,
    FUNC_GET_MIN    = 2'd2,
    FUNC_BUCKET_MIN = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_SKIPPED     = 2'd1,
    ST_NOT_IN_LIST = 2'd2,
    ST_LIST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISP, S_U_CHK, S_W_RD, S_W_CHK, S_V_CHK, S_INS1, S_INS2,
    S_D_CHK, S_D_CLR, S_G_CHK, S_B_RD, S_B_CHK, S_FIN
  } state_e;

  typedef enum logic [2:0] {
    RD_SLOT, RD_HEAD, RD_TAIL, RD_NXT, RD_BKT
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE, WR_INIT, WR_UNLINK, WR_INS_SELF, WR_INS_NEIGH, WR_CLEAR
  } wr_op_e;

  typedef struct packed {
    rd_sel_e rd_sel;
    wr_op_e  wr_op;
    logic    init_adv;
    logic    item_ld;
    logic    walk_init;
    logic    walk_adv;
    logic    p_ld;
    logic    bkt_adv;
    logic    bkt_hit;
    logic    set_stat;
    status_e stat;
    logic    res_last;
    logic    out_ld;
  } cmd_t;

  typedef struct packed {
    logic  init_last;
    func_e func;
    logic  guard_eq;
    logic  word_zero;
    logic  slot_ok;
    logic  slot_in_tbl;
    logic  rd_linked;
    logic  walk_stop;
    logic  walk_last;
    logic  last_is_head;
    logic  bkt_end;
  } sts_t;

  function automatic logic [ID_W-1:0] valid_id(input logic [ID_W-1:0] id);
    return (32'(id) < TABLE_SIZE) ? id : TAIL_ID;
  endfunction

endpackage

// ===== design/spl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority list channels
// Request and response valid/ready channels of the list engine.
// ----------------------------------------------------------------------------
interface spl_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 func;
  logic [spl_pkg::SLOT_W-1:0]  slot;
  logic [spl_pkg::NPRIO_W-1:0] new_priority;
  logic [spl_pkg::WORD_W-1:0]  slot_word;
  logic [spl_pkg::WORD_W-1:0]  expected_word;
  logic [spl_pkg::WAY_W-1:0]   way_count;

  modport source (output valid, func, slot, new_priority, slot_word, expected_word,
                  way_count, input ready);
  modport sink (input valid, func, slot, new_priority, slot_word, expected_word,
                way_count, output ready);
endinterface

interface spl_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [spl_pkg::RES_W-1:0] result_slot;
  logic                      bucket_empty;

  modport source (output valid, status, result_slot, bucket_empty, input ready);
  modport sink (input valid, status, result_slot, bucket_empty, output ready);
endinterface

// ===== design/spl_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority list datapath
// Link and priority tables, walk and bucket registers, result registers.
// ----------------------------------------------------------------------------
module spl_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  spl_pkg::cmd_t               cmd_i,
  output spl_pkg::sts_t               sts_o,
  input  logic [1:0]                  func_i,
  input  logic [spl_pkg::SLOT_W-1:0]  slot_i,
  input  logic [spl_pkg::NPRIO_W-1:0] new_priority_i,
  input  logic [spl_pkg::WORD_W-1:0]  slot_word_i,
  input  logic [spl_pkg::WORD_W-1:0]  expected_word_i,
  input  logic [spl_pkg::WAY_W-1:0]   way_count_i,
  output logic [1:0]                  status_o,
  output logic [spl_pkg::RES_W-1:0]   result_slot_o,
  output logic                        bucket_empty_o
);

  logic [spl_pkg::ID_W-1:0]          next_mem [spl_pkg::TABLE_SIZE];
  logic [spl_pkg::ID_W-1:0]          prev_mem [spl_pkg::TABLE_SIZE];
  logic signed [spl_pkg::PRIO_W-1:0] prio_mem [spl_pkg::TABLE_SIZE];

  logic [spl_pkg::ID_W-1:0]          rd_next_q, rd_prev_q, rd_addr;
  logic signed [spl_pkg::PRIO_W-1:0] rd_prio_q;

  logic                              next_we, prev_we, prio_we;
  logic [spl_pkg::ID_W-1:0]          next_wa, prev_wa, prio_wa, next_wd, prev_wd;
  logic signed [spl_pkg::PRIO_W-1:0] prio_wd;

  logic [spl_pkg::ID_W-1:0]          init_q;
  spl_pkg::func_e                    func_q;
  logic [spl_pkg::SLOT_W-1:0]        slot_q;
  logic signed [spl_pkg::PRIO_W-1:0] prio_q;
  logic [spl_pkg::I_W-1:0]           ways_q, ways_d, i_q;
  logic                              guard_eq_q, word_zero_q;
  logic [spl_pkg::ID_W-1:0]          cur_q, steps_q, p_q, slot_id;
  logic signed [spl_pkg::PRIO_W-1:0] minp_q;
  spl_pkg::status_e                  stat_q;
  logic [spl_pkg::RES_W-1:0]         res_q;
  logic                              empty_q;
  logic [1:0]                        out_stat_q;
  logic [spl_pkg::RES_W-1:0]         out_res_q;
  logic                              out_empty_q;
  logic [spl_pkg::BKT_W-1:0]         bkt_id;
  logic [spl_pkg::ID_W-1:0]          rd_next_v, rd_prev_v;

  assign slot_id   = spl_pkg::ID_W'(slot_q);
  assign bkt_id    = spl_pkg::BKT_W'(slot_q) + spl_pkg::BKT_W'(i_q);
  assign rd_next_v = spl_pkg::valid_id(rd_next_q);
  assign rd_prev_v = spl_pkg::valid_id(rd_prev_q);

  always_comb begin
    if (way_count_i == '0) begin
      ways_d = spl_pkg::I_W'(1);
    end else if (32'(way_count_i) > spl_pkg::MAX_WAYS) begin
      ways_d = spl_pkg::I_W'(spl_pkg::MAX_WAYS);
    end else begin
      ways_d = spl_pkg::I_W'(way_count_i);
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      spl_pkg::RD_SLOT: rd_addr = slot_id;
      spl_pkg::RD_HEAD: rd_addr = spl_pkg::HEAD_ID;
      spl_pkg::RD_TAIL: rd_addr = spl_pkg::TAIL_ID;
      spl_pkg::RD_NXT:  rd_addr = rd_next_v;
      spl_pkg::RD_BKT:  rd_addr = bkt_id[spl_pkg::ID_W-1:0];
      default:          rd_addr = slot_id;
    endcase
  end

  always_comb begin
    next_we = 1'b0;
    prev_we = 1'b0;
    prio_we = 1'b0;
    next_wa = slot_id;
    prev_wa = slot_id;
    prio_wa = slot_id;
    next_wd = '0;
    prev_wd = '0;
    prio_wd = '0;
    case (cmd_i.wr_op)
      spl_pkg::WR_INIT: begin
        next_we = 1'b1;
        prev_we = 1'b1;
        prio_we = 1'b1;
        next_wa = init_q;
        prev_wa = init_q;
        prio_wa = init_q;
        if (init_q == spl_pkg::HEAD_ID) begin
          next_wd = spl_pkg::TAIL_ID;
          prev_wd = spl_pkg::TAIL_ID;
          prio_wd = spl_pkg::HEAD_PRIO;
        end else if (init_q == spl_pkg::TAIL_ID) begin
          next_wd = spl_pkg::HEAD_ID;
          prev_wd = spl_pkg::HEAD_ID;
          prio_wd = spl_pkg::TAIL_PRIO;
        end
      end
      spl_pkg::WR_UNLINK: begin
        next_we = 1'b1;
        prev_we = 1'b1;
        next_wa = rd_prev_v;
        next_wd = rd_next_v;
        prev_wa = rd_next_v;
        prev_wd = rd_prev_v;
      end
      spl_pkg::WR_INS_SELF: begin
        next_we = 1'b1;
        prev_we = 1'b1;
        prio_we = 1'b1;
        next_wd = cur_q;
        prev_wd = p_q;
        prio_wd = prio_q;
      end
      spl_pkg::WR_INS_NEIGH: begin
        next_we = 1'b1;
        prev_we = 1'b1;
        prev_wa = cur_q;
        prev_wd = slot_id;
        next_wa = p_q;
        next_wd = slot_id;
      end
      spl_pkg::WR_CLEAR: begin
        next_we = 1'b1;
        prev_we = 1'b1;
        prio_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    rd_next_q <= next_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    rd_prev_q <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (prio_we) begin
      prio_mem[prio_wa] <= prio_wd;
    end
    rd_prio_q <= prio_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
    end else if (cmd_i.init_adv) begin
      init_q <= init_q + spl_pkg::ID_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_ld) begin
      func_q      <= spl_pkg::func_e'(func_i);
      slot_q      <= slot_i;
      prio_q      <= spl_pkg::PRIO_W'(new_priority_i);
      ways_q      <= ways_d;
      guard_eq_q  <= (slot_word_i == expected_word_i);
      word_zero_q <= (slot_word_i == '0);
      i_q         <= '0;
      stat_q      <= spl_pkg::ST_DONE;
      res_q       <= '0;
      empty_q     <= 1'b0;
    end
    if (cmd_i.walk_init) begin
      cur_q   <= spl_pkg::HEAD_ID;
      steps_q <= '0;
    end
    if (cmd_i.walk_adv) begin
      cur_q   <= rd_next_v;
      steps_q <= steps_q + spl_pkg::ID_W'(1);
    end
    if (cmd_i.p_ld) begin
      p_q <= rd_prev_v;
    end
    if (cmd_i.bkt_adv) begin
      if (i_q == '0 || rd_prio_q < minp_q) begin
        minp_q <= rd_prio_q;
        res_q  <= spl_pkg::RES_W'(i_q);
      end
      i_q <= i_q + spl_pkg::I_W'(1);
    end
    if (cmd_i.bkt_hit) begin
      res_q   <= spl_pkg::RES_W'(i_q);
      empty_q <= 1'b1;
    end
    if (cmd_i.set_stat) begin
      stat_q <= cmd_i.stat;
    end
    if (cmd_i.res_last) begin
      res_q <= spl_pkg::RES_W'(rd_prev_v);
    end
    if (cmd_i.out_ld) begin
      out_stat_q  <= stat_q;
      out_res_q   <= res_q;
      out_empty_q <= empty_q;
    end
  end

  always_comb begin
    sts_o.init_last    = (32'(init_q) == spl_pkg::TABLE_SIZE - 1);
    sts_o.func         = func_q;
    sts_o.guard_eq     = guard_eq_q;
    sts_o.word_zero    = word_zero_q;
    sts_o.slot_ok      = (32'(slot_q) < spl_pkg::SLOT_COUNT);
    sts_o.slot_in_tbl  = (32'(slot_q) < spl_pkg::TABLE_SIZE);
    sts_o.rd_linked    = (rd_next_q != rd_prev_q);
    sts_o.walk_stop    = (rd_next_v == spl_pkg::HEAD_ID) || (rd_prio_q <= prio_q);
    sts_o.walk_last    = (32'(steps_q) == spl_pkg::TABLE_SIZE - 1);
    sts_o.last_is_head = (rd_prev_v == spl_pkg::HEAD_ID);
    sts_o.bkt_end      = (i_q >= ways_q) || (32'(bkt_id) >= spl_pkg::TABLE_SIZE);
  end

  assign status_o       = out_stat_q;
  assign result_slot_o  = out_res_q;
  assign bucket_empty_o = out_empty_q;

endmodule

// ===== design/spl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority list controller
// Sequences table clearing, operations and the response beat.
// ----------------------------------------------------------------------------
module spl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  input  spl_pkg::sts_t sts_i,
  output spl_pkg::cmd_t cmd_o
);

  spl_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            fin_go;

  assign fin_go = !out_valid_q || rsp_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      spl_pkg::S_INIT: if (sts_i.init_last) state_d = spl_pkg::S_IDLE;
      spl_pkg::S_IDLE: if (req_valid_i) state_d = spl_pkg::S_DISP;
      spl_pkg::S_DISP: begin
        case (sts_i.func)
          spl_pkg::FUNC_UPDATE: begin
            if (!sts_i.guard_eq || !sts_i.slot_ok) state_d = spl_pkg::S_FIN;
            else state_d = spl_pkg::S_U_CHK;
          end
          spl_pkg::FUNC_DELETE: begin
            if (!sts_i.word_zero || !sts_i.slot_ok) state_d = spl_pkg::S_FIN;
            else state_d = spl_pkg::S_D_CHK;
          end
          spl_pkg::FUNC_GET_MIN: state_d = spl_pkg::S_G_CHK;
          default: begin
            if (!sts_i.slot_in_tbl) state_d = spl_pkg::S_FIN;
            else state_d = spl_pkg::S_B_RD;
          end
        endcase
      end
      spl_pkg::S_U_CHK: state_d = spl_pkg::S_W_RD;
      spl_pkg::S_W_RD:  state_d = spl_pkg::S_W_CHK;
      spl_pkg::S_W_CHK: begin
        if (sts_i.walk_stop) state_d = spl_pkg::S_INS1;
        else if (sts_i.walk_last) state_d = spl_pkg::S_V_CHK;
      end
      spl_pkg::S_V_CHK: state_d = spl_pkg::S_INS1;
      spl_pkg::S_INS1:  state_d = spl_pkg::S_INS2;
      spl_pkg::S_INS2:  state_d = spl_pkg::S_FIN;
      spl_pkg::S_D_CHK: begin
        if (sts_i.rd_linked) state_d = spl_pkg::S_D_CLR;
        else state_d = spl_pkg::S_FIN;
      end
      spl_pkg::S_D_CLR: state_d = spl_pkg::S_FIN;
      spl_pkg::S_G_CHK: state_d = spl_pkg::S_FIN;
      spl_pkg::S_B_RD: begin
        if (sts_i.bkt_end) state_d = spl_pkg::S_FIN;
        else state_d = spl_pkg::S_B_CHK;
      end
      spl_pkg::S_B_CHK: begin
        if (sts_i.rd_linked) state_d = spl_pkg::S_B_RD;
        else state_d = spl_pkg::S_FIN;
      end
      spl_pkg::S_FIN: if (fin_go) state_d = spl_pkg::S_IDLE;
      default: state_d = spl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.rd_sel   = spl_pkg::RD_SLOT;
    cmd_o.wr_op    = spl_pkg::WR_NONE;
    cmd_o.stat     = spl_pkg::ST_DONE;
    req_ready_o    = 1'b0;
    case (state_q)
      spl_pkg::S_INIT: begin
        cmd_o.wr_op    = spl_pkg::WR_INIT;
        cmd_o.init_adv = 1'b1;
      end
      spl_pkg::S_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.item_ld = req_valid_i;
      end
      spl_pkg::S_DISP: begin
        case (sts_i.func)
          spl_pkg::FUNC_UPDATE: begin
            if (!sts_i.guard_eq) begin
              cmd_o.set_stat = 1'b1;
              cmd_o.stat     = spl_pkg::ST_SKIPPED;
            end else if (!sts_i.slot_ok) begin
              cmd_o.set_stat = 1'b1;
              cmd_o.stat     = spl_pkg::ST_NOT_IN_LIST;
            end
          end
          spl_pkg::FUNC_DELETE: begin
            if (!sts_i.word_zero) begin
              cmd_o.set_stat = 1'b1;
              cmd_o.stat     = spl_pkg::ST_SKIPPED;
            end else if (!sts_i.slot_ok) begin
              cmd_o.set_stat = 1'b1;
              cmd_o.stat     = spl_pkg::ST_NOT_IN_LIST;
            end
          end
          spl_pkg::FUNC_GET_MIN: cmd_o.rd_sel = spl_pkg::RD_TAIL;
          default: begin
            if (!sts_i.slot_in_tbl) begin
              cmd_o.set_stat = 1'b1;
              cmd_o.stat     = spl_pkg::ST_NOT_IN_LIST;
            end
          end
        endcase
      end
      spl_pkg::S_U_CHK: if (sts_i.rd_linked) cmd_o.wr_op = spl_pkg::WR_UNLINK;
      spl_pkg::S_W_RD: begin
        cmd_o.rd_sel    = spl_pkg::RD_HEAD;
        cmd_o.walk_init = 1'b1;
      end
      spl_pkg::S_W_CHK: begin
        if (sts_i.walk_stop) begin
          cmd_o.p_ld = 1'b1;
        end else begin
          cmd_o.walk_adv = 1'b1;
          cmd_o.rd_sel   = spl_pkg::RD_NXT;
        end
      end
      spl_pkg::S_V_CHK: cmd_o.p_ld = 1'b1;
      spl_pkg::S_INS1:  cmd_o.wr_op = spl_pkg::WR_INS_SELF;
      spl_pkg::S_INS2:  cmd_o.wr_op = spl_pkg::WR_INS_NEIGH;
      spl_pkg::S_D_CHK: begin
        if (sts_i.rd_linked) begin
          cmd_o.wr_op = spl_pkg::WR_UNLINK;
        end else begin
          cmd_o.set_stat = 1'b1;
          cmd_o.stat     = spl_pkg::ST_NOT_IN_LIST;
        end
      end
      spl_pkg::S_D_CLR: cmd_o.wr_op = spl_pkg::WR_CLEAR;
      spl_pkg::S_G_CHK: begin
        if (sts_i.last_is_head) begin
          cmd_o.set_stat = 1'b1;
          cmd_o.stat     = spl_pkg::ST_LIST_EMPTY;
        end else begin
          cmd_o.res_last = 1'b1;
        end
      end
      spl_pkg::S_B_RD: cmd_o.rd_sel = spl_pkg::RD_BKT;
      spl_pkg::S_B_CHK: begin
        if (sts_i.rd_linked) cmd_o.bkt_adv = 1'b1;
        else cmd_o.bkt_hit = 1'b1;
      end
      spl_pkg::S_FIN: cmd_o.out_ld = fin_go;
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_ld) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spl_pkg::S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_valid_o = out_valid_q;

endmodule

// ===== design/sorted_priority_list_engine_core.sv =====
`timescale 1ns / 1ps
// One request at a time; an update walks the list from its head, up to 1026 entries.
// A bucket minimum scan ends early at the first unlinked slot of the bucket.
// Walk speed is set by the single read port of the link tables: one walk step per cycle.
// The response register frees the engine while a result beat waits to be taken.
// After reset a clearing pass over all table entries rebuilds the empty list first.
// ----------------------------------------------------------------------------
// Sorted priority list engine
// Doubly linked list over a slot table, sorted by descending priority.
// ----------------------------------------------------------------------------
module sorted_priority_list_engine_core (
  input  logic clk_i,
  input  logic rst_ni,
  spl_req_if.sink   req,
  spl_rsp_if.source rsp
);

  spl_pkg::cmd_t cmd;
  spl_pkg::sts_t sts;

  spl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spl_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .func_i          (req.func),
    .slot_i          (req.slot),
    .new_priority_i  (req.new_priority),
    .slot_word_i     (req.slot_word),
    .expected_word_i (req.expected_word),
    .way_count_i     (req.way_count),
    .status_o        (rsp.status),
    .result_slot_o   (rsp.result_slot),
    .bucket_empty_o  (rsp.bucket_empty)
  );

endmodule
